/* src/lsge_pkg.sv */
package lsge_pkg;

  localparam int CoordW      = 18;
  localparam int OutW        = 21;
  localparam int NodeW       = 5;
  localparam int KindW       = 3;
  localparam int OrderW      = 2;
  localparam int WordW       = 48;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 3;
  localparam int FracBitsDef = 16;

  localparam logic [CfgIdxW-1:0] CfgKind  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOrder = 2'd1;

  typedef enum logic [KindW-1:0] {
    KindSeg  = 3'd0,
    KindTri  = 3'd1,
    KindQuad = 3'd2,
    KindTet  = 3'd3,
    KindHex  = 3'd4
  } kind_e;

  typedef logic signed [WordW-1:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t d;
  } axis_t;

  typedef struct packed {
    logic             valid;
    logic [NodeW-1:0] node;
    logic             last;
    logic             simp;
  } meta_t;

  // {ix, iy, iz}, two bits each
  localparam logic [5:0] HEX1_TAB [8] = '{
    6'b000000, 6'b010000, 6'b010100, 6'b000100,
    6'b000001, 6'b010001, 6'b010101, 6'b000101};
  localparam logic [5:0] HEX2_TAB [27] = '{
    6'b000000, 6'b100000, 6'b101000, 6'b001000,
    6'b000010, 6'b100010, 6'b101010, 6'b001010,
    6'b010000, 6'b100100, 6'b011000, 6'b000100,
    6'b000001, 6'b100001, 6'b101001, 6'b001001,
    6'b010010, 6'b100110, 6'b011010, 6'b000110,
    6'b010100, 6'b010001, 6'b100101, 6'b011001,
    6'b000101, 6'b010110, 6'b010101};
  // {ix, iy}
  localparam logic [3:0] QUAD1_TAB [4] = '{4'b0000, 4'b0100, 4'b0101, 4'b0001};
  localparam logic [3:0] QUAD2_TAB [9] = '{
    4'b0000, 4'b1000, 4'b1010, 4'b0010, 4'b0100,
    4'b1001, 4'b0110, 4'b0001, 4'b0101};
  // {a, b} barycentric pair
  localparam logic [3:0] TRI2_TAB [6] = '{
    4'b0000, 4'b0101, 4'b1010, 4'b0100, 4'b1000, 4'b0110};
  localparam logic [3:0] TET2_TAB [10] = '{
    4'b0000, 4'b0101, 4'b1010, 4'b1111, 4'b0100,
    4'b1000, 4'b0110, 4'b1100, 4'b0111, 4'b1011};

  function automatic logic [NodeW-1:0] node_count(logic [KindW-1:0] kind, logic quad);
    logic [NodeW-1:0] n;
    case (kind)
      KindSeg:  n = quad ? 5'd3  : 5'd2;
      KindTri:  n = quad ? 5'd6  : 5'd3;
      KindQuad: n = quad ? 5'd9  : 5'd4;
      KindTet:  n = quad ? 5'd10 : 5'd4;
      KindHex:  n = quad ? 5'd27 : 5'd8;
      default:  n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [5:0] tens_sel(logic [KindW-1:0] kind, logic quad,
                                          logic [NodeW-1:0] node);
    logic [5:0] r;
    case (kind)
      KindSeg:  r = {node[1:0], 4'b0000};
      KindQuad: r = quad ? {QUAD2_TAB[node[3:0]], 2'b00} : {QUAD1_TAB[node[1:0]], 2'b00};
      KindHex:  r = quad ? HEX2_TAB[node] : HEX1_TAB[node[2:0]];
      default:  r = 6'b000000;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] simp_sel(logic tet, logic quad, logic [NodeW-1:0] node);
    logic [3:0] r;
    if (!quad) begin
      r = {node[1:0], node[1:0]};
    end else if (tet) begin
      r = TET2_TAB[node[3:0]];
    end else begin
      r = TRI2_TAB[node[2:0]];
    end
    return r;
  endfunction

  function automatic logic signed [OutW-1:0] sat_out(word_t v);
    logic signed [OutW-1:0] r;
    if (v > word_t'((1 << (OutW - 1)) - 1)) begin
      r = {1'b0, {(OutW-1){1'b1}}};
    end else if (v < -word_t'(1 << (OutW - 1))) begin
      r = {1'b1, {(OutW-1){1'b0}}};
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

endpackage

/* src/lsge_qmul.sv */
module lsge_qmul #(
  parameter int unsigned FRAC_BITS = lsge_pkg::FracBitsDef
) (
  input  logic           clk_i,
  input  lsge_pkg::word_t a_i,
  input  lsge_pkg::word_t b_i,
  output lsge_pkg::word_t p_o
);
  import lsge_pkg::*;

  localparam int HalfW = WordW / 2;
  localparam int PartW = 2 * HalfW;
  localparam int ProdW = 2 * WordW;
  localparam logic [WordW-1:0] Wlim = {1'b0, {(WordW-1){1'b1}}};

  logic [WordW-1:0] ua, ub, mag;
  logic [PartW-1:0] pp_ll_d, pp_lh_d, pp_hl_d, pp_hh_d;
  logic [PartW-1:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic             neg_d, neg_q;
  logic [ProdW-1:0] prod, rnd, sh;
  word_t            p_d, p_q;

  // partial products of the magnitudes, registered first
  always_comb begin
    neg_d   = a_i[WordW-1] ^ b_i[WordW-1];
    ua      = a_i[WordW-1] ? WordW'(-a_i) : WordW'(a_i);
    ub      = b_i[WordW-1] ? WordW'(-b_i) : WordW'(b_i);
    pp_ll_d = PartW'(ua[HalfW-1:0]) * PartW'(ub[HalfW-1:0]);
    pp_lh_d = PartW'(ua[HalfW-1:0]) * PartW'(ub[WordW-1:HalfW]);
    pp_hl_d = PartW'(ua[WordW-1:HalfW]) * PartW'(ub[HalfW-1:0]);
    pp_hh_d = PartW'(ua[WordW-1:HalfW]) * PartW'(ub[WordW-1:HalfW]);
  end

  always_ff @(posedge clk_i) begin
    pp_ll_q <= pp_ll_d;
    pp_lh_q <= pp_lh_d;
    pp_hl_q <= pp_hl_d;
    pp_hh_q <= pp_hh_d;
    neg_q   <= neg_d;
  end

  // then: sum of the partial products, rounded half away from zero, saturated and registered
  always_comb begin
    prod = ProdW'(pp_ll_q) + (ProdW'(pp_lh_q) << HalfW) + (ProdW'(pp_hl_q) << HalfW)
         + (ProdW'(pp_hh_q) << WordW);
    rnd  = prod + (ProdW'(1) << (FRAC_BITS - 1));
    sh   = rnd >> FRAC_BITS;
    mag  = (sh > ProdW'(Wlim)) ? Wlim : sh[WordW-1:0];
    p_d  = neg_q ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

/* src/lagrange_shape_gradient_eval_unit.sv */
// results: once a request is taken, one node per cycle
// throughput: one node per cycle through an eight-stage pipeline with registered multipliers;
// a request yields one result per node of its element (2 to 27), and the next one may
// start as soon as its last node is issued
// reset: element_kind 0, poly_order 1, pipeline empty
// here the receiver cannot stall: res_valid_o is high with each node's result
module lagrange_shape_gradient_eval_unit #(
  parameter int unsigned FRAC_BITS = lsge_pkg::FracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [lsge_pkg::CoordW-1:0]  coord_x_i,
  input  logic signed [lsge_pkg::CoordW-1:0]  coord_y_i,
  input  logic signed [lsge_pkg::CoordW-1:0]  coord_z_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lsge_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lsge_pkg::CfgDataW-1:0]       cfg_data_i,
  output logic                                res_valid_o,
  output logic [lsge_pkg::NodeW-1:0]          node_index_o,
  output logic signed [lsge_pkg::OutW-1:0]    shape_value_o,
  output logic signed [lsge_pkg::OutW-1:0]    grad_x_o,
  output logic signed [lsge_pkg::OutW-1:0]    grad_y_o,
  output logic signed [lsge_pkg::OutW-1:0]    grad_z_o,
  output logic                                last_node_o
);
  import lsge_pkg::*;

  localparam word_t One = word_t'(1) << FRAC_BITS;

  // configuration
  logic [KindW-1:0]  kind_cfg_q;
  logic [OrderW-1:0] order_cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_cfg_q  <= KindSeg;
      order_cfg_q <= OrderW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgKind:  kind_cfg_q  <= cfg_data_i;
        CfgOrder: order_cfg_q <= cfg_data_i[OrderW-1:0];
        default: ;
      endcase
    end
  end

  // node sequencer
  logic                     act_q, act_d;
  logic [NodeW-1:0]         node_q, node_d, last_q, last_d;
  logic [KindW-1:0]         kind_q, kind_d;
  logic                     quad_q, quad_d;
  word_t                    x_q, y_q, z_q, x_d, y_d, z_d;
  logic                     accept;
  logic [NodeW-1:0]         cnt;

  assign busy_o = act_q && (node_q != last_q);
  assign accept = start_i && !busy_o;

  always_comb begin
    act_d  = act_q;
    node_d = node_q;
    last_d = last_q;
    kind_d = kind_q;
    quad_d = quad_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt    = node_count(kind_cfg_q, order_cfg_q >= OrderW'(2));
    if (act_q) begin
      if (node_q != last_q) begin
        node_d = node_q + NodeW'(1);
      end else begin
        act_d = 1'b0;
      end
    end
    if (accept) begin
      x_d    = word_t'(coord_x_i);
      y_d    = word_t'(coord_y_i);
      z_d    = word_t'(coord_z_i);
      kind_d = kind_cfg_q;
      quad_d = order_cfg_q >= OrderW'(2);
      if (cnt != '0) begin
        act_d  = 1'b1;
        node_d = '0;
        last_d = cnt - NodeW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      node_q <= '0;
      last_q <= '0;
    end else begin
      act_q  <= act_d;
      node_q <= node_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    quad_q <= quad_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  // stage 1: operand selection
  function automatic axis_t axis_fn(word_t c, logic [1:0] idx, logic quad);
    axis_t r;
    r.a = One;
    r.b = One;
    r.d = '0;
    if (!quad) begin
      case (idx)
        2'd0: begin
          r.a = One - c;
          r.d = -One;
        end
        2'd1: begin
          r.a = c;
          r.d = One;
        end
        default: begin
          r.a = '0;
        end
      endcase
    end else begin
      case (idx)
        2'd0: begin
          r.a = One - c;
          r.b = One - (c <<< 1);
          r.d = (c <<< 2) - ((One <<< 1) + One);
        end
        2'd1: begin
          r.a = c <<< 2;
          r.b = One - c;
          r.d = (One <<< 2) - (c <<< 3);
        end
        default: begin
          r.a = c;
          r.b = (c <<< 1) - One;
          r.d = (c <<< 2) - One;
        end
      endcase
    end
    return r;
  endfunction

  function automatic word_t dmul(logic [1:0] a, logic [1:0] k, logic tet, word_t v);
    word_t r;
    r = '0;
    if (a == 2'd0 && (k != 2'd2 || tet)) begin
      r = -v;
    end else if (a == k + 2'd1) begin
      r = v;
    end
    return r;
  endfunction

  axis_t            ax_s1, ay_s1, az_s1;
  logic             simp_s1, tet_s1;
  logic [5:0]       tsel;
  logic [3:0]       ssel;
  word_t            lam [4];
  word_t            la, lb;
  axis_t            ax1_q, ay1_q, az1_q;
  meta_t            m1_q, m2_q, m3_q, m4_q, m5_q, m6_q, m7_q, m8_q;

  always_comb begin
    simp_s1 = (kind_q == KindTri) || (kind_q == KindTet);
    tet_s1  = (kind_q == KindTet);
    tsel    = tens_sel(kind_q, quad_q, node_q);
    ssel    = simp_sel(tet_s1, quad_q, node_q);
    lam[0]  = One - x_q - y_q - (tet_s1 ? z_q : '0);
    lam[1]  = x_q;
    lam[2]  = y_q;
    lam[3]  = tet_s1 ? z_q : '0;
    la      = lam[ssel[3:2]];
    lb      = lam[ssel[1:0]];
    ax_s1   = axis_fn(x_q, tsel[5:4], quad_q);
    ay_s1   = axis_fn(y_q, tsel[3:2], quad_q);
    az_s1   = axis_fn(z_q, tsel[1:0], quad_q);
    if (kind_q == KindSeg) begin
      ay_s1 = '{a: One, b: One, d: '0};
    end
    if (kind_q != KindHex) begin
      az_s1 = '{a: One, b: One, d: '0};
    end
    if (simp_s1) begin
      ay_s1.a = One;
      ay_s1.b = One;
      if (!quad_q) begin
        ax_s1.a = la;
        ax_s1.b = One;
        ax_s1.d = dmul(ssel[3:2], 2'd0, tet_s1, One);
        ay_s1.d = dmul(ssel[3:2], 2'd1, tet_s1, One);
        az_s1.d = dmul(ssel[3:2], 2'd2, tet_s1, One);
      end else if (ssel[3:2] == ssel[1:0]) begin
        ax_s1.a = la;
        ax_s1.b = (la <<< 1) - One;
        ax_s1.d = dmul(ssel[3:2], 2'd0, tet_s1, (la <<< 2) - One);
        ay_s1.d = dmul(ssel[3:2], 2'd1, tet_s1, (la <<< 2) - One);
        az_s1.d = dmul(ssel[3:2], 2'd2, tet_s1, (la <<< 2) - One);
      end else begin
        ax_s1.a = la <<< 2;
        ax_s1.b = lb;
        ax_s1.d = (dmul(ssel[3:2], 2'd0, tet_s1, lb) + dmul(ssel[1:0], 2'd0, tet_s1, la)) <<< 2;
        ay_s1.d = (dmul(ssel[3:2], 2'd1, tet_s1, lb) + dmul(ssel[1:0], 2'd1, tet_s1, la)) <<< 2;
        az_s1.d = (dmul(ssel[3:2], 2'd2, tet_s1, lb) + dmul(ssel[1:0], 2'd2, tet_s1, la)) <<< 2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ax1_q <= ax_s1;
    ay1_q <= ay_s1;
    az1_q <= az_s1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= '0;
      m2_q <= '0;
      m3_q <= '0;
      m4_q <= '0;
      m5_q <= '0;
      m6_q <= '0;
      m7_q <= '0;
      m8_q <= '0;
    end else begin
      m1_q <= '{valid: act_q, node: node_q, last: node_q == last_q, simp: simp_s1};
      m2_q <= m1_q;
      m3_q <= m2_q;
      m4_q <= m3_q;
      m5_q <= m4_q;
      m6_q <= m5_q;
      m7_q <= m6_q;
      m8_q <= m7_q;
    end
  end

  // stage 2: 1d basis products
  word_t nx2, ny2, nz2;
  word_t dxa_q, dya_q, dza_q;
  word_t dx2_q, dy2_q, dz2_q;

  lsge_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_nx (
    .clk_i, .a_i(ax1_q.a), .b_i(ax1_q.b), .p_o(nx2));
  lsge_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_ny (
    .clk_i, .a_i(ay1_q.a), .b_i(ay1_q.b), .p_o(ny2));
  lsge_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_nz (
    .clk_i, .a_i(az1_q.a), .b_i(az1_q.b), .p_o(nz2));

  always_ff @(posedge clk_i) begin
    dxa_q <= ax1_q.d;
    dya_q <= ay1_q.d;
    dza_q <= az1_q.d;
    dx2_q <= dxa_q;
    dy2_q <= dya_q;
    dz2_q <= dza_q;
  end

  // stage 3: x-y products
  word_t p3, gx3, gy3;
  word_t nzb_q, dzb_q, nz3_q, dz3_q;

  lsge_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_p3 (
    .clk_i, .a_i(nx2), .b_i(ny2), .p_o(p3));
  lsge_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_gx3 (
    .clk_i, .a_i(dx2_q), .b_i(ny2), .p_o(gx3));
  lsge_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_gy3 (
    .clk_i, .a_i(m3_q.simp ? dy2_q : nx2), .b_i(m3_q.simp ? ny2 : dy2_q), .p_o(gy3));

  always_ff @(posedge clk_i) begin
    nzb_q <= nz2;
    dzb_q <= dz2_q;
    nz3_q <= nzb_q;
    dz3_q <= dzb_q;
  end

  // stage 4: z products
  word_t s4, gx4, gy4, gz4;

  lsge_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_s4 (
    .clk_i, .a_i(p3), .b_i(nz3_q), .p_o(s4));
  lsge_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_gx4 (
    .clk_i, .a_i(gx3), .b_i(nz3_q), .p_o(gx4));
  lsge_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_gy4 (
    .clk_i, .a_i(gy3), .b_i(nz3_q), .p_o(gy4));
  lsge_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_gz4 (
    .clk_i, .a_i(m5_q.simp ? dz3_q : p3), .b_i(m5_q.simp ? nz3_q : dz3_q), .p_o(gz4));

  // stage 5: output saturation
  logic signed [OutW-1:0] shape_q, gx_q, gy_q, gz_q;

  always_ff @(posedge clk_i) begin
    shape_q <= sat_out(s4);
    gx_q    <= sat_out(gx4);
    gy_q    <= sat_out(gy4);
    gz_q    <= sat_out(gz4);
  end

  assign res_valid_o   = m8_q.valid;
  assign node_index_o  = m8_q.node;
  assign last_node_o   = m8_q.last;
  assign shape_value_o = shape_q;
  assign grad_x_o      = gx_q;
  assign grad_y_o      = gy_q;
  assign grad_z_o      = gz_q;

  a_node_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> node_index_o <= NodeW'(26))
    else $error("node index out of range");

  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_node_o |=> !res_valid_o || node_index_o == '0)
    else $error("result after last node is not node zero");

  a_node_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_node_o |=>
      res_valid_o && node_index_o == $past(node_index_o) + NodeW'(1))
    else $error("node sequence broken");

endmodule
